// ===== design/cms_pkg.sv =====
// Shared constants, types and defaults for the count-min sketch engine.
// No dependencies; the other design files except cms_ram refer to it by scoped names.
package cms_pkg;

  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int INC_W      = 32;
  localparam int EST_W      = 32;
  localparam int TOT_W      = 64;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int ROWS_CFG_W = 4;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_DEPTH = 8;
  localparam int DEF_KEY_BYTES = 8;

  localparam logic [CFG_W-1:0]      RST_ROW_WIDTH = 11'd1024;
  localparam logic [ROWS_CFG_W-1:0] RST_ROW_COUNT = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [INC_W-1:0] inc;
  } item_t;

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    xorshift = x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

// ===== design/count_min_sketch_update_query_core.sv =====
// Count-min sketch engine top: config registers, front queue, back engine.
// Per row: 2 to 5 hash multiplies on the shared multiplier, a bit-serial modulo, a counter RMW.
// The back engine works on one item at a time, its pace set by the shared multiplier and
// the one-bit-per-cycle modulo; the front queue holds up to two waiting items.
// After reset all MAX_WIDTH*MAX_DEPTH counter words are cleared, busy held high.
// Depends on cms_pkg, cms_front, cms_back, cms_ram.
module count_min_sketch_update_query_core #(
  parameter int MAX_WIDTH = cms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH = cms_pkg::DEF_MAX_DEPTH,
  parameter int KEY_BYTES = cms_pkg::DEF_KEY_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cms_pkg::KEY_W-1:0]     in_key_bytes,
  input  logic [cms_pkg::LEN_W-1:0]     in_key_length,
  input  logic [cms_pkg::INC_W-1:0]     in_increment,
  output logic                          out_valid,
  output logic [cms_pkg::EST_W-1:0]     out_estimate,
  output logic [cms_pkg::TOT_W-1:0]     out_sum_total,
  input  logic                          cfg_we,
  input  logic [cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cms_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_DEPTH + 1);

  logic [cms_pkg::CFG_W-1:0]      width_r;
  logic [cms_pkg::ROWS_CFG_W-1:0] rows_r;
  logic [WW-1:0]                  w_eff;
  logic [RW-1:0]                  d_eff;
  logic                           full, clearing, item_valid, pop, push;
  cms_pkg::item_t                 item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= cms_pkg::RST_ROW_WIDTH;
      rows_r  <= cms_pkg::RST_ROW_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        cms_pkg::REG_ROW_WIDTH: width_r <= cfg_data;
        cms_pkg::REG_ROW_COUNT: rows_r  <= cfg_data[cms_pkg::ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (rows_r == '0) d_eff = RW'(1);
    else if (32'(rows_r) > 32'(MAX_DEPTH)) d_eff = RW'(MAX_DEPTH);
    else d_eff = RW'(rows_r);
  end

  assign busy = full || clearing;
  assign push = start && !busy;

  cms_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .key        (in_key_bytes),
    .len        (in_key_length),
    .inc        (in_increment),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop)
  );

  cms_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .pop         (pop),
    .w           (w_eff),
    .d           (d_eff),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .estimate    (out_estimate),
    .sum_total   (out_sum_total)
  );

endmodule

// ===== design/cms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cms_front.sv =====
// Front end: clamps key length, masks unused key bytes, queues items.
// Depends on cms_pkg.
module cms_front #(
  parameter int KEY_BYTES = cms_pkg::DEF_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [cms_pkg::KEY_W-1:0]  key,
  input  logic [cms_pkg::LEN_W-1:0]  len,
  input  logic [cms_pkg::INC_W-1:0]  inc,
  output logic                       full,
  output logic                       item_valid,
  output cms_pkg::item_t             item,
  input  logic                       pop
);

  cms_pkg::item_t               cls;
  logic [cms_pkg::LEN_W-1:0]    len_c;
  cms_pkg::item_t               q_r [2];
  logic                         wp_r, rp_r;
  logic [1:0]                   cnt_r;

  always_comb begin
    len_c = (len > cms_pkg::LEN_W'(KEY_BYTES)) ? cms_pkg::LEN_W'(KEY_BYTES) : len;
    cls.len = len_c;
    cls.inc = inc;
    for (int i = 0; i < 8; i++) begin
      cls.key[8*i +: 8] = (cms_pkg::LEN_W'(i) < len_c) ? key[8*i +: 8] : 8'h00;
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/cms_back.sv =====
// Back end: per-row hash with a shared 32x32 multiplier, bit-serial modulo,
// counter read-modify-write, minimum and running total. Depends on cms_pkg, cms_ram.
module cms_back #(
  parameter int MAX_WIDTH = cms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH = cms_pkg::DEF_MAX_DEPTH,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_DEPTH + 1),
  localparam int STORE = MAX_WIDTH * MAX_DEPTH,
  localparam int AW = (STORE > 1) ? $clog2(STORE) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  cms_pkg::item_t            item,
  output logic                      pop,
  input  logic [WW-1:0]             w,
  input  logic [RW-1:0]             d,
  output logic                      clearing,
  output logic                      out_valid,
  output logic [cms_pkg::EST_W-1:0] estimate,
  output logic [cms_pkg::TOT_W-1:0] sum_total
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_MUL, S_DIV, S_RD, S_WR, S_DONE} state_t;
  typedef enum logic [2:0] {P_LEN, P_K1, P_K2, P_H1, P_F1} phase_t;

  state_t                     state_r;
  phase_t                     phase_r;
  logic [1:0]                 mcnt_r;
  logic [63:0]                opa_r, prod_r, acc_r, h_r, key_r, div_r;
  logic [cms_pkg::LEN_W-1:0]  len_r;
  logic [cms_pkg::INC_W-1:0]  inc_r;
  logic [RW-1:0]              row_r;
  logic [AW-1:0]              base_r, addr_r, clr_r;
  logic [5:0]                 dcnt_r;
  logic [WW-1:0]              rem_r;
  logic [31:0]                best_r;
  logic [63:0]                total_r;
  logic                       out_valid_r;
  logic [31:0]                est_r;
  logic [63:0]                out_total_r;

  logic [31:0] ma, mb;
  logic [63:0] prod_nxt, p, hv, seed;
  logic [WW:0] remsh;
  logic [WW-1:0] rem_nxt;
  logic [32:0] sum_w;
  logic [31:0] sum, ram_rdata, wdata;
  logic [64:0] tsum;
  logic [63:0] tnew;
  logic        we;
  logic [AW-1:0] waddr;

  always_comb begin
    case (mcnt_r)
      2'd0: begin ma = opa_r[31:0];  mb = cms_pkg::MIX_MUL[31:0];  end
      2'd1: begin ma = opa_r[31:0];  mb = cms_pkg::MIX_MUL[63:32]; end
      default: begin ma = opa_r[63:32]; mb = cms_pkg::MIX_MUL[31:0]; end
    endcase
    prod_nxt = 64'(ma) * 64'(mb);
    p        = acc_r + {prod_r[31:0], 32'h0};
    seed     = 64'(row_r);
    hv       = seed ^ p;
    remsh    = {rem_r, div_r[63]};
    rem_nxt  = (remsh >= {1'b0, w}) ? WW'(remsh - {1'b0, w}) : remsh[WW-1:0];
    sum_w    = {1'b0, ram_rdata} + {1'b0, inc_r};
    sum      = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    tsum     = {1'b0, total_r} + 65'(inc_r);
    tnew     = tsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tsum[63:0];
    we       = (state_r == S_CLR) || (state_r == S_WR);
    waddr    = (state_r == S_CLR) ? clr_r : addr_r;
    wdata    = (state_r == S_CLR) ? 32'h0 : sum;
  end

  assign pop         = (state_r == S_IDLE) && item_valid;
  assign clearing    = (state_r == S_CLR);
  assign out_valid   = out_valid_r;
  assign estimate    = est_r;
  assign sum_total   = out_total_r;

  cms_ram #(.WIDTH(32), .DEPTH(STORE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(STORE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            key_r   <= item.key;
            len_r   <= item.len;
            inc_r   <= item.inc;
            row_r   <= '0;
            base_r  <= '0;
            best_r  <= 32'hFFFF_FFFF;
            opa_r   <= 64'(item.len);
            phase_r <= P_LEN;
            mcnt_r  <= 2'd0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          mcnt_r <= mcnt_r + 2'd1;
          case (mcnt_r)
            2'd0: ;
            2'd1: acc_r <= prod_r;
            2'd2: acc_r <= p;
            default: begin
              case (phase_r)
                P_LEN: begin
                  if (len_r >= cms_pkg::LEN_W'(8)) begin
                    h_r     <= hv;
                    opa_r   <= key_r;
                    phase_r <= P_K1;
                  end else if (len_r != '0) begin
                    opa_r   <= hv ^ key_r;
                    phase_r <= P_H1;
                  end else begin
                    opa_r   <= cms_pkg::xorshift(hv);
                    phase_r <= P_F1;
                  end
                end
                P_K1: begin
                  opa_r   <= cms_pkg::xorshift(p);
                  phase_r <= P_K2;
                end
                P_K2: begin
                  opa_r   <= h_r ^ p;
                  phase_r <= P_H1;
                end
                P_H1: begin
                  opa_r   <= cms_pkg::xorshift(p);
                  phase_r <= P_F1;
                end
                default: begin
                  div_r   <= cms_pkg::xorshift(p);
                  rem_r   <= '0;
                  dcnt_r  <= '0;
                  state_r <= S_DIV;
                end
              endcase
            end
          endcase
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          div_r  <= div_r << 1;
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd63) begin
            addr_r  <= base_r + AW'(rem_nxt);
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_WR;
        end
        S_WR: begin
          if (sum < best_r) best_r <= sum;
          row_r  <= row_r + 1'b1;
          base_r <= base_r + AW'(w);
          if (row_r + 1'b1 == d) begin
            state_r <= S_DONE;
          end else begin
            opa_r   <= 64'(len_r);
            phase_r <= P_LEN;
            mcnt_r  <= 2'd0;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          total_r     <= tnew;
          out_total_r <= tnew;
          est_r       <= best_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cms_checker.sv =====
// Port-level checks for the count-min sketch engine, bound to the top level.
// Depends on cms_pkg and count_min_sketch_update_query_core.
module cms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [cms_pkg::EST_W-1:0]     out_estimate,
  input logic [cms_pkg::TOT_W-1:0]     out_sum_total
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid) else $error("result right after accept");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  a_est_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (64'(out_estimate) <= out_sum_total))
    else $error("estimate above total");

endmodule

bind count_min_sketch_update_query_core cms_checker u_cms_checker (.*);

// ===== bench/count_min_sketch_update_query_core_tb.sv =====
// Self-checking bench for count_min_sketch_update_query_core: directed and random keys,
// increments and sketch settings, checked against a local count-min predictor.
// Depends on cms_pkg and the design sources only.
module count_min_sketch_update_query_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = cms_pkg::DEF_MAX_WIDTH * cms_pkg::DEF_MAX_DEPTH;
  localparam int IDLE_LIMIT  = 40000;

  typedef struct {
    logic [cms_pkg::EST_W-1:0] estimate;
    logic [cms_pkg::TOT_W-1:0] total;
  } sketch_result_t;

  class sketch_scoreboard;
    logic [31:0]                    counters [STORE_DEPTH];
    logic [cms_pkg::TOT_W-1:0]      total;
    logic [cms_pkg::CFG_W-1:0]      width_reg;
    logic [cms_pkg::ROWS_CFG_W-1:0] rows_reg;
    sketch_result_t                 pending [$];
    int                             errors;
    int                             items;
    int                             results;

    function new();
      foreach (counters[i]) counters[i] = '0;
      total     = '0;
      width_reg = cms_pkg::RST_ROW_WIDTH;
      rows_reg  = cms_pkg::RST_ROW_COUNT;
      errors    = 0;
      items     = 0;
      results   = 0;
    endfunction

    function void set_reg(logic [cms_pkg::CFG_IDX_W-1:0] idx, logic [cms_pkg::CFG_W-1:0] val);
      if (idx == cms_pkg::REG_ROW_WIDTH) width_reg = val;
      else if (idx == cms_pkg::REG_ROW_COUNT) rows_reg = val[cms_pkg::ROWS_CFG_W-1:0];
    endfunction

    function logic [63:0] murmur64(logic [63:0] key, int unsigned len, logic [63:0] seed);
      logic [63:0] h;
      logic [63:0] k;
      h = seed ^ (64'(len) * cms_pkg::MIX_MUL);
      if (len >= 8) begin
        k = key * cms_pkg::MIX_MUL;
        k = k ^ (k >> cms_pkg::MIX_SHIFT);
        k = k * cms_pkg::MIX_MUL;
        h = (h ^ k) * cms_pkg::MIX_MUL;
      end else if (len > 0) begin
        h = (h ^ key) * cms_pkg::MIX_MUL;
      end
      h = h ^ (h >> cms_pkg::MIX_SHIFT);
      h = h * cms_pkg::MIX_MUL;
      h = h ^ (h >> cms_pkg::MIX_SHIFT);
      return h;
    endfunction

    function void note_item(logic [cms_pkg::KEY_W-1:0] key, logic [cms_pkg::LEN_W-1:0] len_in,
                            logic [cms_pkg::INC_W-1:0] inc);
      int unsigned w;
      int unsigned d;
      int unsigned len;
      int unsigned col;
      int unsigned idx;
      logic [32:0] sum;
      logic [31:0] best;
      logic [64:0] tsum;
      sketch_result_t res;
      w = width_reg;
      d = rows_reg;
      len = len_in;
      if (w < 1) w = 1;
      if (w > cms_pkg::DEF_MAX_WIDTH) w = cms_pkg::DEF_MAX_WIDTH;
      if (d < 1) d = 1;
      if (d > cms_pkg::DEF_MAX_DEPTH) d = cms_pkg::DEF_MAX_DEPTH;
      if (len > cms_pkg::DEF_KEY_BYTES) len = cms_pkg::DEF_KEY_BYTES;
      if (len < 8) key = key & ((64'd1 << (8 * len)) - 64'd1);
      best = '1;
      for (int unsigned r = 0; r < d; r++) begin
        col = int'(murmur64(key, len, 64'(r)) % 64'(w));
        idx = r * w + col;
        sum = {1'b0, counters[idx]} + {1'b0, inc};
        if (sum[32]) sum[31:0] = '1;
        counters[idx] = sum[31:0];
        if (sum[31:0] < best) best = sum[31:0];
      end
      tsum = {1'b0, total} + 65'(inc);
      total = tsum[64] ? '1 : tsum[63:0];
      res.estimate = best;
      res.total = total;
      pending.push_back(res);
      items++;
    endfunction

    function void check_result(logic [cms_pkg::EST_W-1:0] est, logic [cms_pkg::TOT_W-1:0] tot);
      sketch_result_t exp_res;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result: estimate %0d sum_total %0d", est, tot);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (est !== exp_res.estimate) begin
        $error("estimate: expected %0d, actual %0d", exp_res.estimate, est);
        errors++;
      end
      if (tot !== exp_res.total) begin
        $error("sum_total: expected %0d, actual %0d", exp_res.total, tot);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [cms_pkg::KEY_W-1:0]     in_key_bytes;
  logic [cms_pkg::LEN_W-1:0]     in_key_length;
  logic [cms_pkg::INC_W-1:0]     in_increment;
  logic                          out_valid;
  logic [cms_pkg::EST_W-1:0]     out_estimate;
  logic [cms_pkg::TOT_W-1:0]     out_sum_total;
  logic                          cfg_we;
  logic [cms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cms_pkg::CFG_W-1:0]     cfg_data;

  sketch_scoreboard sb;
  logic [63:0] key_pool [8];
  bit          no_gaps;
  int          idle_cycles;

  count_min_sketch_update_query_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_key_bytes   (in_key_bytes),
    .in_key_length  (in_key_length),
    .in_increment   (in_increment),
    .out_valid      (out_valid),
    .out_estimate   (out_estimate),
    .out_sum_total  (out_sum_total),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_estimate, out_sum_total);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(logic [cms_pkg::KEY_W-1:0] key, logic [cms_pkg::LEN_W-1:0] len,
                           logic [cms_pkg::INC_W-1:0] inc);
    int gap;
    start         <= 1'b1;
    in_key_bytes  <= key;
    in_key_length <= len;
    in_increment  <= inc;
    do @(posedge clk); while (busy);
    sb.note_item(key, len, inc);
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_sketch_cfg(logic [cms_pkg::CFG_W-1:0] width_val,
                                  logic [cms_pkg::CFG_W-1:0] rows_val);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cms_pkg::REG_ROW_WIDTH;
    cfg_data  <= width_val;
    sb.set_reg(cms_pkg::REG_ROW_WIDTH, width_val);
    @(posedge clk);
    cfg_index <= cms_pkg::REG_ROW_COUNT;
    cfg_data  <= rows_val;
    sb.set_reg(cms_pkg::REG_ROW_COUNT, rows_val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(int count);
    logic [cms_pkg::KEY_W-1:0] key;
    logic [cms_pkg::LEN_W-1:0] len;
    logic [cms_pkg::INC_W-1:0] inc;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      key = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, 7)]
                                       : {$urandom, $urandom};
      len = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      case ($urandom_range(0, 9))
        0, 1:    inc = '0;
        2:       inc = '1;
        3, 4:    inc = {$urandom} | 32'h8000_0000;
        5:       inc = $urandom;
        default: inc = $urandom_range(1, 100);
      endcase
      send_item(key, len, inc);
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    start         = 1'b0;
    in_key_bytes  = '0;
    in_key_length = '0;
    in_increment  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    idle_cycles   = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_item(64'h0, 4'd0, 32'd0);
    send_item(64'h0, 4'd0, 32'd5);
    send_item('1, 4'd8, '1);
    send_item('1, 4'd8, '1);
    send_item('1, 4'd8, 32'd0);
    send_item(64'hdead_beef_0012_3456, 4'd3, 32'd7);
    send_item(64'h0000_0000_0012_3456, 4'd3, 32'd1);
    send_item(64'h0123_4567_89ab_cdef, 4'd12, 32'd9);
    send_item(64'h0123_4567_89ab_cdef, 4'd15, 32'd0);
    send_item(64'h0123_4567_89ab_cdef, 4'd8, 32'd0);
    for (int l = 1; l < 8; l++) send_item(64'hffee_ddcc_bbaa_9988, 4'(l), 32'h8000_0000);
    send_item(64'h5555_aaaa_5555_aaaa, 4'd8, 32'h7fff_ffff);

    write_sketch_cfg(11'd1, 11'd1);
    send_item(64'h1, 4'd1, '1);
    send_item(64'h2, 4'd1, 32'd3);
    write_sketch_cfg(11'd0, 11'd0);
    send_item(64'h3, 4'd1, 32'd0);
    write_sketch_cfg(11'd2047, 11'd15);
    send_item(64'h4, 4'd2, 32'd1);

    write_sketch_cfg(11'd1024, 11'd8);
    random_batch(130);
    write_sketch_cfg(11'd1, 11'd1);
    random_batch(130);
    write_sketch_cfg(11'd7, 11'd3);
    random_batch(130);
    write_sketch_cfg(11'd2047, 11'd15);
    random_batch(100);
    write_sketch_cfg(11'd0, 11'd0);
    random_batch(130);
    write_sketch_cfg(11'd1024, 11'd4);
    random_batch(130);
    for (int p = 0; p < 3; p++) begin
      write_sketch_cfg(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 15)));
      random_batch(90);
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d items and %0d results over several width and row settings.",
             sb.items, sb.results);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
